### design/chm_pkg.sv
// shared types, constants and helper functions for the chained hash map engine
package chm_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int MAX_BUCKETS = 4096;
  localparam int MIN_BUCKETS = 16;
  localparam int ROTATE_BITS = 4;

  localparam int ENT_AW  = $clog2(MAX_ENTRIES);      // pool index bits
  localparam int LINK_W  = ENT_AW + 1;               // link incl. empty marker
  localparam int BKT_AW  = $clog2(MAX_BUCKETS);      // bucket index bits
  localparam int BRAM_AW = BKT_AW + 1;               // two banks of heads
  localparam int LOG_W   = $clog2(BKT_AW + 1);
  localparam int MIN_LOG = $clog2(MIN_BUCKETS);
  localparam int MAX_LOG = BKT_AW;
  localparam int TGT_W   = BKT_AW + 4;               // wide enough for 10*count

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_ENTRIES);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [63:0] key;
    logic [63:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_value;
  } out_item_t;

  // bucket mask for a given table size
  function automatic logic [BKT_AW-1:0] bkt_mask(input logic [LOG_W-1:0] lg);
    logic [BKT_AW:0] full;
    full = ({{BKT_AW{1'b0}}, 1'b1} << lg) - {{BKT_AW{1'b0}}, 1'b1};
    return full[BKT_AW-1:0];
  endfunction

  // bucket index: key rotated right, low bits kept
  function automatic logic [BKT_AW-1:0] bkt_index(input logic [63:0] k,
                                                  input logic [LOG_W-1:0] lg);
    logic [63:0] rot;
    rot = (k >> ROTATE_BITS) | (k << (64 - ROTATE_BITS));
    return rot[BKT_AW-1:0] & bkt_mask(lg);
  endfunction

  // smallest log with 2^log >= floor(10*c/3), clamped to the size limits
  function automatic logic [LOG_W-1:0] target_log(input logic [LINK_W-1:0] c);
    logic [TGT_W-1:0] ten_c;
    logic [LOG_W-1:0] res;
    ten_c = TGT_W'(c) * TGT_W'(10);
    res   = LOG_W'(MAX_LOG);
    for (int lg = MAX_LOG; lg >= MIN_LOG; lg--) begin
      if (ten_c <= TGT_W'(3 * (1 << lg) + 2)) res = LOG_W'(lg);
    end
    return res;
  endfunction

endpackage

### design/chm_bucket_ram.sv
// bucket head memory, two banks, one write and one registered read port
module chm_bucket_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [chm_pkg::BRAM_AW-1:0] waddr,
  input  logic [chm_pkg::LINK_W-1:0]  wdata,
  input  logic [chm_pkg::BRAM_AW-1:0] raddr,
  output logic [chm_pkg::LINK_W-1:0]  rdata
);

  logic [chm_pkg::LINK_W-1:0] mem [2*chm_pkg::MAX_BUCKETS];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/chm_entry_ram.sv
// entry pool memory: key, value and chain link per entry
module chm_entry_ram (
  input  logic                       clk,
  input  logic                       kd_we,
  input  logic [chm_pkg::ENT_AW-1:0] kd_addr,
  input  logic [63:0]                kd_key,
  input  logic [63:0]                kd_data,
  input  logic                       ln_we,
  input  logic [chm_pkg::ENT_AW-1:0] ln_addr,
  input  logic [chm_pkg::LINK_W-1:0] ln_data,
  input  logic [chm_pkg::ENT_AW-1:0] raddr,
  output logic [63:0]                rd_key,
  output logic [63:0]                rd_data,
  output logic [chm_pkg::LINK_W-1:0] rd_link
);

  logic [63:0]                key_mem  [chm_pkg::MAX_ENTRIES];
  logic [63:0]                data_mem [chm_pkg::MAX_ENTRIES];
  logic [chm_pkg::LINK_W-1:0] link_mem [chm_pkg::MAX_ENTRIES];

  // key and value written together on insert
  always_ff @(posedge clk) begin
    if (kd_we) begin
      key_mem[kd_addr]  <= kd_key;
      data_mem[kd_addr] <= kd_data;
    end
  end

  // chain link write
  always_ff @(posedge clk) begin
    if (ln_we) link_mem[ln_addr] <= ln_data;
  end

  // registered read of one entry
  always_ff @(posedge clk) begin
    rd_key  <= key_mem[raddr];
    rd_data <= data_mem[raddr];
    rd_link <= link_mem[raddr];
  end

endmodule

### design/chained_hash_map_engine.sv
// Chained hash map engine: 64-bit keys to 64-bit values by separate chaining
// over a pool of 1024 entries. One transaction at a time; a lookup reads the
// bucket head, then walks the chain one entry at a time, and an insert stores
// the entry, then links it in front of its chain head; a full pool refuses it.
// An insert that grows the table also rehashes first: it clears 2^new_log
// heads of the spare bank, then reads each old bucket and moves its entries.
// After reset a clearing pass empties the first 16 heads of bucket bank 0,
// and no transaction is accepted during it. A result waits in an output
// register; the next transaction is taken once that result has gone.
module chained_hash_map_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  chm_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output chm_pkg::out_item_t out_data
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISP     = 4'd2;
  localparam logic [3:0] S_RH_CLR   = 4'd3;
  localparam logic [3:0] S_RH_BRD   = 4'd4;
  localparam logic [3:0] S_RH_BWAIT = 4'd5;
  localparam logic [3:0] S_RH_EWAIT = 4'd6;
  localparam logic [3:0] S_RH_HWAIT = 4'd7;
  localparam logic [3:0] S_RH_NEXTB = 4'd8;
  localparam logic [3:0] S_INS_RD   = 4'd9;
  localparam logic [3:0] S_INS_WR   = 4'd10;
  localparam logic [3:0] S_LK_HEAD  = 4'd11;
  localparam logic [3:0] S_LK_CMP   = 4'd12;

  logic [3:0]                    state_r, state_nxt;
  logic                          bank_r, bank_nxt;
  logic [chm_pkg::LOG_W-1:0]     log_r, log_nxt;
  logic [chm_pkg::LOG_W-1:0]     nl_r, nl_nxt;
  logic [chm_pkg::LINK_W-1:0]    count_r, count_nxt;
  logic [chm_pkg::BKT_AW-1:0]    cnt_r, cnt_nxt;
  logic [chm_pkg::ENT_AW-1:0]    e_r, e_nxt;
  logic [chm_pkg::LINK_W-1:0]    nxt_r, nxt_nxt;
  logic [chm_pkg::BKT_AW-1:0]    idx_r, idx_nxt;
  logic                          op_r, op_nxt;
  logic [63:0]                   key_r, key_nxt;
  logic [63:0]                   val_r, val_nxt;
  logic                          out_valid_r, out_valid_nxt;
  chm_pkg::out_item_t            out_r, out_nxt;

  logic                          b_we;
  logic [chm_pkg::BRAM_AW-1:0]   b_waddr, b_raddr;
  logic [chm_pkg::LINK_W-1:0]    b_wdata, b_rdata;
  logic                          kd_we, ln_we;
  logic [chm_pkg::ENT_AW-1:0]    ln_addr, e_raddr;
  logic [chm_pkg::LINK_W-1:0]    ln_data;
  logic [63:0]                   e_key, e_data;
  logic [chm_pkg::LINK_W-1:0]    e_link;

  logic [chm_pkg::LINK_W-1:0]    newc;
  logic [chm_pkg::BKT_AW+1:0]    newc2, nbkt;
  logic [chm_pkg::LOG_W-1:0]     tgt;
  logic [chm_pkg::BKT_AW-1:0]    cur_idx;

  chm_bucket_ram u_bkt (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  chm_entry_ram u_ent (
    .clk     (clk),
    .kd_we   (kd_we),
    .kd_addr (count_r[chm_pkg::ENT_AW-1:0]),
    .kd_key  (key_r),
    .kd_data (val_r),
    .ln_we   (ln_we),
    .ln_addr (ln_addr),
    .ln_data (ln_data),
    .raddr   (e_raddr),
    .rd_key  (e_key),
    .rd_data (e_data),
    .rd_link (e_link)
  );

  // grow check for the insert in hand
  assign newc    = count_r + chm_pkg::LINK_W'(1);
  assign newc2   = {(chm_pkg::BKT_AW + 2 - chm_pkg::LINK_W)'(0), newc} << 1;
  assign nbkt    = {{(chm_pkg::BKT_AW + 1){1'b0}}, 1'b1} << log_r;
  assign tgt     = chm_pkg::target_log(newc);
  assign cur_idx = chm_pkg::bkt_index(key_r, log_r);

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    bank_nxt      = bank_r;
    log_nxt       = log_r;
    nl_nxt        = nl_r;
    count_nxt     = count_r;
    cnt_nxt       = cnt_r;
    e_nxt         = e_r;
    nxt_nxt       = nxt_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    b_we          = 1'b0;
    b_waddr       = {bank_r, cnt_r};
    b_wdata       = chm_pkg::LINK_NONE;
    b_raddr       = {bank_r, cur_idx};
    kd_we         = 1'b0;
    ln_we         = 1'b0;
    ln_addr       = e_r;
    ln_data       = b_rdata;
    e_raddr       = e_r;

    unique case (state_r)
      S_INIT: begin
        b_we    = 1'b1;
        b_waddr = {1'b0, cnt_r};
        cnt_nxt = cnt_r + chm_pkg::BKT_AW'(1);
        if (cnt_r == chm_pkg::bkt_mask(log_r)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt    = in_data.opcode;
          key_nxt   = in_data.key;
          val_nxt   = in_data.data_value;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (op_r == chm_pkg::OP_LOOKUP) begin
          state_nxt = S_LK_HEAD;
        end else if (count_r == chm_pkg::LINK_W'(chm_pkg::MAX_ENTRIES)) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: chm_pkg::ST_FULL, found_value: 64'd0};
          state_nxt     = S_IDLE;
        end else if (newc2 > nbkt && tgt != log_r) begin
          nl_nxt    = tgt;
          cnt_nxt   = '0;
          state_nxt = S_RH_CLR;
        end else begin
          state_nxt = S_INS_RD;
        end
      end
      // empty the spare bank over the new size
      S_RH_CLR: begin
        b_we    = 1'b1;
        b_waddr = {!bank_r, cnt_r};
        cnt_nxt = cnt_r + chm_pkg::BKT_AW'(1);
        if (cnt_r == chm_pkg::bkt_mask(nl_r)) begin
          cnt_nxt   = '0;
          state_nxt = S_RH_BRD;
        end
      end
      S_RH_BRD: begin
        b_raddr   = {bank_r, cnt_r};
        state_nxt = S_RH_BWAIT;
      end
      S_RH_BWAIT: begin
        e_raddr = b_rdata[chm_pkg::ENT_AW-1:0];
        if (b_rdata == chm_pkg::LINK_NONE) begin
          state_nxt = S_RH_NEXTB;
        end else begin
          e_nxt     = b_rdata[chm_pkg::ENT_AW-1:0];
          state_nxt = S_RH_EWAIT;
        end
      end
      // entry in hand: fetch the head of its new chain
      S_RH_EWAIT: begin
        nxt_nxt   = e_link;
        idx_nxt   = chm_pkg::bkt_index(e_key, nl_r);
        b_raddr   = {!bank_r, chm_pkg::bkt_index(e_key, nl_r)};
        state_nxt = S_RH_HWAIT;
      end
      // prepend entry to its new chain
      S_RH_HWAIT: begin
        ln_we   = 1'b1;
        b_we    = 1'b1;
        b_waddr = {!bank_r, idx_r};
        b_wdata = {1'b0, e_r};
        e_raddr = nxt_r[chm_pkg::ENT_AW-1:0];
        if (nxt_r == chm_pkg::LINK_NONE) begin
          state_nxt = S_RH_NEXTB;
        end else begin
          e_nxt     = nxt_r[chm_pkg::ENT_AW-1:0];
          state_nxt = S_RH_EWAIT;
        end
      end
      S_RH_NEXTB: begin
        if (cnt_r == chm_pkg::bkt_mask(log_r)) begin
          cnt_nxt   = '0;
          bank_nxt  = !bank_r;
          log_nxt   = nl_r;
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt   = cnt_r + chm_pkg::BKT_AW'(1);
          state_nxt = S_RH_BRD;
        end
      end
      // store entry and read its chain head
      S_INS_RD: begin
        kd_we     = 1'b1;
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        ln_we         = 1'b1;
        ln_addr       = count_r[chm_pkg::ENT_AW-1:0];
        b_we          = 1'b1;
        b_waddr       = {bank_r, cur_idx};
        b_wdata       = count_r;
        count_nxt     = newc;
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: chm_pkg::ST_OK, found_value: 64'd0};
        state_nxt     = S_IDLE;
      end
      S_LK_HEAD: begin
        e_raddr = b_rdata[chm_pkg::ENT_AW-1:0];
        if (b_rdata == chm_pkg::LINK_NONE) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: chm_pkg::ST_NOTFOUND, found_value: 64'd0};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_LK_CMP;
        end
      end
      // walk the chain one entry a cycle
      S_LK_CMP: begin
        e_raddr = e_link[chm_pkg::ENT_AW-1:0];
        if (e_key == key_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: chm_pkg::ST_OK, found_value: e_data};
          state_nxt     = S_IDLE;
        end else if (e_link == chm_pkg::LINK_NONE) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: chm_pkg::ST_NOTFOUND, found_value: 64'd0};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      bank_r      <= 1'b0;
      log_r       <= chm_pkg::LOG_W'(chm_pkg::MIN_LOG);
      count_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      log_r       <= log_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    nl_r  <= nl_nxt;
    e_r   <= e_nxt;
    nxt_r <= nxt_nxt;
    idx_r <= idx_nxt;
    op_r  <= op_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    out_r <= out_nxt;
  end

endmodule
